// ===== rtl/pcp_pkg.sv =====
// Package for the point-in-convex-polygon test.
// Holds coordinate widths, edge job and queue status types.
// No dependencies.
package pcp_pkg;

  localparam int COORD_BITS = 16;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * DIFF_BITS;
  localparam int CROSS_BITS = PROD_BITS + 1;
  localparam int DOT_BITS   = CROSS_BITS + COORD_BITS;
  localparam int SUM_BITS   = DOT_BITS + 2;

  localparam int JQ_DEPTH = 4;
  localparam int JQ_AW    = $clog2(JQ_DEPTH);

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
  } vec_t;

  typedef struct packed {
    vec_t a;
    vec_t b;
    vec_t p;
    vec_t n;
    logic emit;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// ===== rtl/point_in_convex_polygon_test.sv =====
// Same-side test of a query point against a convex polygon face.
// Vertex words enter through a push/full queue port, one per vertex in
// winding order, each carrying the query point and face normal; one
// result word (point_inside) appears on the empty/pop port per face, after
// the word marked last_vertex. A vertex word is taken every cycle while the
// job queue has room. A last vertex word that closes a face of two or more
// vertices holds the input until its closing edge job is written, because the
// front end writes one edge job per cycle into the job queue while it has room
// and such a word makes two. Each edge job runs through a five-stage pipeline
// (difference, products, cross, dot, sign) to the result port; the pipeline stalls
// while the result queue is full. Top level; depends on pcp_pkg, pcp_front,
// pcp_job_queue and pcp_back.
module point_in_convex_polygon_test (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  output logic                                  full,
  input  logic signed [pcp_pkg::COORD_BITS-1:0] vert_x,
  input  logic signed [pcp_pkg::COORD_BITS-1:0] vert_y,
  input  logic signed [pcp_pkg::COORD_BITS-1:0] vert_z,
  input  logic signed [pcp_pkg::COORD_BITS-1:0] point_x,
  input  logic signed [pcp_pkg::COORD_BITS-1:0] point_y,
  input  logic signed [pcp_pkg::COORD_BITS-1:0] point_z,
  input  logic signed [pcp_pkg::COORD_BITS-1:0] normal_x,
  input  logic signed [pcp_pkg::COORD_BITS-1:0] normal_y,
  input  logic signed [pcp_pkg::COORD_BITS-1:0] normal_z,
  input  logic                                  last_vertex,
  output logic                                  empty,
  input  logic                                  pop,
  output logic                                  point_inside
);

  pcp_pkg::vec_t          vert;
  pcp_pkg::vec_t          point;
  pcp_pkg::vec_t          normal;
  pcp_pkg::queue_status_t jq_status;
  logic                   jq_push;
  logic                   jq_pop;
  pcp_pkg::job_t          jq_in;
  pcp_pkg::job_t          jq_head;

  assign vert   = '{x: vert_x, y: vert_y, z: vert_z};
  assign point  = '{x: point_x, y: point_y, z: point_z};
  assign normal = '{x: normal_x, y: normal_y, z: normal_z};

  pcp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .vert        (vert),
    .point       (point),
    .normal      (normal),
    .last_vertex (last_vertex),
    .jq_status   (jq_status),
    .jq_push     (jq_push),
    .jq_job      (jq_in)
  );

  pcp_job_queue u_job_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (jq_push),
    .push_job (jq_in),
    .pop      (jq_pop),
    .head_job (jq_head),
    .status   (jq_status)
  );

  pcp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .jq_status    (jq_status),
    .jq_job       (jq_head),
    .jq_pop       (jq_pop),
    .empty        (empty),
    .pop          (pop),
    .point_inside (point_inside)
  );

endmodule

// ===== rtl/pcp_front.sv =====
// Front end: accepts vertex words and turns them into edge jobs.
// Keeps the first and previous vertex of the face. Depends on pcp_pkg.
module pcp_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  pcp_pkg::vec_t                       vert,
  input  pcp_pkg::vec_t                       point,
  input  pcp_pkg::vec_t                       normal,
  input  logic                                last_vertex,
  input  pcp_pkg::queue_status_t              jq_status,
  output logic                                jq_push,
  output pcp_pkg::job_t                       jq_job
);

  pcp_pkg::vec_t first_vertex;
  pcp_pkg::vec_t previous_vertex;
  logic          face_started;
  logic          pending;
  pcp_pkg::job_t pend_job;
  logic          accept;

  assign full   = pending | jq_status.full;
  assign accept = push & ~full;

  always_comb begin
    jq_push = 1'b0;
    jq_job  = pend_job;
    if (pending) begin
      jq_push = ~jq_status.full;
    end else if (accept) begin
      if (face_started) begin
        jq_push = 1'b1;
        jq_job  = '{a: previous_vertex, b: vert, p: point, n: normal, emit: 1'b0};
      end else if (last_vertex) begin
        jq_push = 1'b1;
        jq_job  = '{a: vert, b: vert, p: point, n: normal, emit: 1'b1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      face_started <= 1'b0;
      pending      <= 1'b0;
    end else begin
      if (pending && jq_push) begin
        pending <= 1'b0;
      end
      if (accept) begin
        face_started <= ~last_vertex;
        if (face_started && last_vertex) begin
          pending <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      previous_vertex <= vert;
      if (!face_started) begin
        first_vertex <= vert;
      end
      pend_job <= '{a: vert, b: first_vertex, p: point, n: normal, emit: 1'b1};
    end
  end

endmodule

// ===== rtl/pcp_job_queue.sv =====
// Short queue of edge jobs between the front end and the edge unit.
// Register storage, one write and one read port. Depends on pcp_pkg.
module pcp_job_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  pcp_pkg::job_t          push_job,
  input  logic                   pop,
  output pcp_pkg::job_t          head_job,
  output pcp_pkg::queue_status_t status
);

  pcp_pkg::job_t            mem [pcp_pkg::JQ_DEPTH];
  logic [pcp_pkg::JQ_AW-1:0] wr_ptr;
  logic [pcp_pkg::JQ_AW-1:0] rd_ptr;
  logic [pcp_pkg::JQ_AW:0]   count;
  logic                      do_push;
  logic                      do_pop;

  assign status.full  = (count == (pcp_pkg::JQ_AW + 1)'(pcp_pkg::JQ_DEPTH));
  assign status.empty = (count == '0);
  assign do_push      = push & ~status.full;
  assign do_pop       = pop & ~status.empty;
  assign head_job     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    !(push && status.full))
    else $error("job pushed into full queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (pcp_pkg::JQ_AW + 1)'(pcp_pkg::JQ_DEPTH))
    else $error("job queue count out of range");

  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    (do_pop && !do_push) |=> (count == $past(count) - 1'b1))
    else $error("job queue count did not drop on pop");

endmodule

// ===== rtl/pcp_back.sv =====
// Edge unit: five-stage pipeline computing the sign of (E x W) . N per job,
// the all-edges-pass flag, and a two-word result queue. Depends on pcp_pkg.
module pcp_back (
  input  logic                   clk,
  input  logic                   rst,
  input  pcp_pkg::queue_status_t jq_status,
  input  pcp_pkg::job_t          jq_job,
  output logic                   jq_pop,
  output logic                   empty,
  input  logic                   pop,
  output logic                   point_inside
);

  localparam int DW = pcp_pkg::DIFF_BITS;
  localparam int PW = pcp_pkg::PROD_BITS;
  localparam int CW = pcp_pkg::CROSS_BITS;
  localparam int NW = pcp_pkg::DOT_BITS;
  localparam int SW = pcp_pkg::SUM_BITS;

  logic                en;
  logic [1:0]          ocount;
  logic                ohead;
  logic                otail;
  logic                omem [2];

  logic                s1_valid, s2_valid, s3_valid, s4_valid;
  logic                s1_emit, s2_emit, s3_emit, s4_emit;
  logic signed [DW-1:0] e [3];
  logic signed [DW-1:0] w [3];
  pcp_pkg::vec_t       s1_n, s2_n, s3_n;
  logic signed [PW-1:0] m [6];
  logic signed [CW-1:0] c [3];
  logic signed [NW-1:0] q [3];
  logic signed [SW-1:0] dot_sum;
  logic                edge_ok;
  logic                acc_pass;
  logic                res_push;

  assign en      = (ocount != 2'd2);
  assign jq_pop  = en & ~jq_status.empty;
  assign empty   = (ocount == 2'd0);
  assign point_inside = omem[ohead];

  assign dot_sum  = SW'(q[0]) + SW'(q[1]) + SW'(q[2]);
  assign edge_ok  = ~dot_sum[SW-1];
  assign res_push = en & s4_valid & s4_emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      acc_pass <= 1'b1;
    end else if (en) begin
      s1_valid <= ~jq_status.empty;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      if (s4_valid) begin
        acc_pass <= s4_emit ? 1'b1 : (acc_pass & edge_ok);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e[0]    <= DW'(jq_job.b.x) - DW'(jq_job.a.x);
      e[1]    <= DW'(jq_job.b.y) - DW'(jq_job.a.y);
      e[2]    <= DW'(jq_job.b.z) - DW'(jq_job.a.z);
      w[0]    <= DW'(jq_job.p.x) - DW'(jq_job.a.x);
      w[1]    <= DW'(jq_job.p.y) - DW'(jq_job.a.y);
      w[2]    <= DW'(jq_job.p.z) - DW'(jq_job.a.z);
      s1_n    <= jq_job.n;
      s1_emit <= jq_job.emit;

      m[0]    <= PW'(e[1]) * PW'(w[2]);
      m[1]    <= PW'(e[2]) * PW'(w[1]);
      m[2]    <= PW'(e[2]) * PW'(w[0]);
      m[3]    <= PW'(e[0]) * PW'(w[2]);
      m[4]    <= PW'(e[0]) * PW'(w[1]);
      m[5]    <= PW'(e[1]) * PW'(w[0]);
      s2_n    <= s1_n;
      s2_emit <= s1_emit;

      c[0]    <= CW'(m[0]) - CW'(m[1]);
      c[1]    <= CW'(m[2]) - CW'(m[3]);
      c[2]    <= CW'(m[4]) - CW'(m[5]);
      s3_n    <= s2_n;
      s3_emit <= s2_emit;

      q[0]    <= NW'(c[0]) * NW'(s3_n.x);
      q[1]    <= NW'(c[1]) * NW'(s3_n.y);
      q[2]    <= NW'(c[2]) * NW'(s3_n.z);
      s4_emit <= s3_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ocount <= 2'd0;
      ohead  <= 1'b0;
      otail  <= 1'b0;
    end else begin
      if (res_push) begin
        otail <= ~otail;
      end
      if (pop && !empty) begin
        ohead <= ~ohead;
      end
      if (res_push && !(pop && !empty)) begin
        ocount <= ocount + 2'd1;
      end else if (!res_push && pop && !empty) begin
        ocount <= ocount - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      omem[otail] <= acc_pass & edge_ok;
    end
  end

  a_out_bound: assert property (@(posedge clk) disable iff (rst)
    ocount <= 2'd2)
    else $error("result queue count out of range");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (!en && s4_valid) |=> s4_valid)
    else $error("edge pipeline lost a job while stalled");

  a_pass_rearm: assert property (@(posedge clk) disable iff (rst)
    res_push |=> acc_pass)
    else $error("pass flag not rearmed after result");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for point_in_convex_polygon_test: streams polygon faces through
// the push/full port and checks each point_inside word against a predictor.
// Depends on pcp_pkg and the point_in_convex_polygon_test RTL.
module tb_top;
  import pcp_pkg::*;

  typedef struct {
    vec_t vert;
    vec_t pt;
    vec_t nrm;
    logic last;
  } vertex_word_t;

  logic clk = 1'b0;
  logic rst;
  logic push;
  logic full;
  logic signed [COORD_BITS-1:0] vert_x, vert_y, vert_z;
  logic signed [COORD_BITS-1:0] point_x, point_y, point_z;
  logic signed [COORD_BITS-1:0] normal_x, normal_y, normal_z;
  logic last_vertex;
  logic empty;
  logic pop = 1'b0;
  logic point_inside;

  logic inside_expected[$];
  vec_t face_first = '0;
  vec_t face_prev = '0;
  logic face_ok = 1'b1;
  logic face_open = 1'b0;

  int mismatches = 0;
  int vertices_sent = 0;
  int rx_hold = 0;
  int rx_stall = 0;
  bit tx_gaps_on = 1'b1;
  bit rx_gaps_on = 1'b1;
  logic want_inside;

  point_in_convex_polygon_test u_dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .vert_x(vert_x),
    .vert_y(vert_y),
    .vert_z(vert_z),
    .point_x(point_x),
    .point_y(point_y),
    .point_z(point_z),
    .normal_x(normal_x),
    .normal_y(normal_y),
    .normal_z(normal_z),
    .last_vertex(last_vertex),
    .empty(empty),
    .pop(pop),
    .point_inside(point_inside)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("tb_top failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  function automatic logic same_side(vec_t a, vec_t b, vec_t p, vec_t n);
    longint ex, ey, ez, wx, wy, wz, cx, cy, cz, d;
    ex = longint'($signed(b.x)) - longint'($signed(a.x));
    ey = longint'($signed(b.y)) - longint'($signed(a.y));
    ez = longint'($signed(b.z)) - longint'($signed(a.z));
    wx = longint'($signed(p.x)) - longint'($signed(a.x));
    wy = longint'($signed(p.y)) - longint'($signed(a.y));
    wz = longint'($signed(p.z)) - longint'($signed(a.z));
    cx = ey * wz - ez * wy;
    cy = ez * wx - ex * wz;
    cz = ex * wy - ey * wx;
    d = cx * longint'($signed(n.x)) + cy * longint'($signed(n.y))
      + cz * longint'($signed(n.z));
    return d >= 0;
  endfunction

  task automatic track_face_vertex(input vertex_word_t w);
    logic ok;
    ok = face_ok;
    if (!face_open) begin
      face_first = w.vert;
      ok = 1'b1;
      face_open = 1'b1;
    end else if (!same_side(face_prev, w.vert, w.pt, w.nrm)) begin
      ok = 1'b0;
    end
    face_prev = w.vert;
    if (!w.last) begin
      face_ok = ok;
    end else begin
      if (!same_side(w.vert, face_first, w.pt, w.nrm)) ok = 1'b0;
      inside_expected.push_back(ok);
      face_ok = 1'b1;
      face_open = 1'b0;
    end
  endtask

  function automatic vec_t mk_vec(int x, int y, int z);
    vec_t v;
    v.x = 16'(x);
    v.y = 16'(y);
    v.z = 16'(z);
    return v;
  endfunction

  function automatic vertex_word_t mk_word(vec_t v, vec_t p, vec_t n, logic last);
    vertex_word_t w;
    w.vert = v;
    w.pt = p;
    w.nrm = n;
    w.last = last;
    return w;
  endfunction

  function automatic logic [COORD_BITS-1:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic vec_t rand_vec();
    vec_t v;
    v.x = rand_coord();
    v.y = rand_coord();
    v.z = rand_coord();
    return v;
  endfunction

  // map plane coordinates (u, v) and depth h so that u x v points along axis
  function automatic vec_t place(int axis, int u, int v, int h);
    case (axis)
      0: return mk_vec(h, u, v);
      1: return mk_vec(v, h, u);
      default: return mk_vec(u, v, h);
    endcase
  endfunction

  task automatic push_vertex(input vertex_word_t w);
    int gap;
    gap = tx_gaps_on ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    vert_x <= w.vert.x;
    vert_y <= w.vert.y;
    vert_z <= w.vert.z;
    point_x <= w.pt.x;
    point_y <= w.pt.y;
    point_z <= w.pt.z;
    normal_x <= w.nrm.x;
    normal_y <= w.nrm.y;
    normal_z <= w.nrm.z;
    last_vertex <= w.last;
    do @(negedge clk); while (full);
    @(posedge clk);
    vertices_sent++;
    track_face_vertex(w);
  endtask

  task automatic drain_results();
    push <= 1'b0;
    @(posedge clk);
    while (inside_expected.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold = rx_hold - 1;
      pop <= 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall = rx_stall - 1;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  always @(negedge clk) begin
    if (!rst && pop && !empty) begin
      if (inside_expected.size() == 0) begin
        report_mismatch($sformatf("point_inside=%b with no word expected", point_inside));
      end else begin
        want_inside = inside_expected.pop_front();
        if (point_inside !== want_inside)
          report_mismatch($sformatf("point_inside=%b, expected %b", point_inside,
                                    want_inside));
      end
      rx_stall = rx_gaps_on ? $urandom_range(0, 18) : 0;
    end
  end

  task automatic test_single_vertex_faces();
    push_vertex(mk_word(mk_vec(32767, -32768, 0), mk_vec(-32768, 32767, 32767),
                        mk_vec(32767, 32767, -32768), 1'b1));
    push_vertex(mk_word(mk_vec(0, 0, 0), mk_vec(0, 0, 0), mk_vec(0, 0, 0), 1'b1));
    push_vertex(mk_word(mk_vec(-32768, -32768, -32768), mk_vec(-1, -1, -1),
                        mk_vec(-32768, -32768, -32768), 1'b1));
  endtask

  task automatic test_two_vertex_faces();
    push_vertex(mk_word(mk_vec(0, 0, 0), mk_vec(256, 256, 0), mk_vec(0, 0, 256), 1'b0));
    push_vertex(mk_word(mk_vec(512, 512, 0), mk_vec(256, 256, 0), mk_vec(0, 0, 256), 1'b1));
    push_vertex(mk_word(mk_vec(-1000, 200, 300), mk_vec(10, 20, 30),
                        mk_vec(32767, -32768, 1000), 1'b0));
    push_vertex(mk_word(mk_vec(700, -50, -900), mk_vec(10, 20, 30),
                        mk_vec(32767, -32768, 1000), 1'b1));
  endtask

  task automatic test_square_face();
    vec_t sq[4];
    vec_t probe[3];
    vec_t up;
    vec_t down;
    sq = '{mk_vec(0, 0, 0), mk_vec(256, 0, 0), mk_vec(256, 256, 0), mk_vec(0, 256, 0)};
    probe = '{mk_vec(128, 128, 0), mk_vec(512, 128, 0), mk_vec(256, 128, 0)};
    up = mk_vec(0, 0, 256);
    down = mk_vec(0, 0, -256);
    // inside, outside, then on an edge, with the last vertex word carrying a flipped normal
    for (int f = 0; f < 3; f++) begin
      for (int k = 0; k < 4; k++)
        push_vertex(mk_word(sq[k], probe[f], (f == 2 && k == 3) ? down : up, k == 3));
    end
  endtask

  task automatic test_extreme_triangle();
    vec_t p;
    vec_t n;
    p = mk_vec(32767, -32768, 32767);
    n = mk_vec(-32768, 32767, -32768);
    push_vertex(mk_word(mk_vec(-32768, -32768, -32768), p, n, 1'b0));
    push_vertex(mk_word(mk_vec(32767, -32768, 32767), p, n, 1'b0));
    push_vertex(mk_word(mk_vec(32767, 32767, -32768), p, n, 1'b1));
  endtask

  task automatic test_output_backpressure();
    tx_gaps_on = 1'b0;
    rx_hold = 300;
    repeat (40) push_vertex(mk_word(rand_vec(), rand_vec(), rand_vec(), 1'b1));
    drain_results();
    tx_gaps_on = 1'b1;
  endtask

  task automatic test_random_faces();
    int stop_at, kind, n_pts, n_left, idx, axis, nm, h;
    int rx, ry, du, dv, cu, cv, pu, pv;
    int ou[8];
    int ov[8];
    logic [7:0] mask;
    bit rev, vary;
    vertex_word_t w;
    stop_at = vertices_sent + 1000;
    while (vertices_sent < stop_at) begin
      if ($urandom_range(0, 15) == 0) tx_gaps_on = !tx_gaps_on;
      if ($urandom_range(0, 15) == 0) rx_gaps_on = !rx_gaps_on;
      if ($urandom_range(0, 39) == 0) drain_results();
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        // convex subset of an octagon, set in an axis-aligned plane
        rx = $urandom_range(1, 8000);
        ry = $urandom_range(1, 8000);
        du = rx * 7 / 10;
        dv = ry * 7 / 10;
        cu = $urandom_range(0, 16000) - 8000;
        cv = $urandom_range(0, 16000) - 8000;
        h = $urandom_range(0, 65535) - 32768;
        ou = '{rx, du, 0, -du, -rx, -du, 0, du};
        ov = '{0, dv, ry, dv, 0, -dv, -ry, -dv};
        pu = cu + $urandom_range(0, rx * 26 / 10) - rx * 13 / 10;
        pv = cv + $urandom_range(0, ry * 26 / 10) - ry * 13 / 10;
        axis = $urandom_range(0, 2);
        nm = $urandom_range(1, 32767);
        if ($urandom_range(0, 1)) nm = -nm;
        rev = $urandom_range(0, 1);
        mask = 8'($urandom_range(1, 255));
        n_left = $countones(mask);
        for (int k = 0; k < 8; k++) begin
          idx = rev ? 7 - k : k;
          if (mask[idx]) begin
            n_left--;
            w.vert = place(axis, cu + ou[idx], cv + ov[idx], h);
            w.pt = place(axis, pu, pv, h + $urandom_range(0, 512) - 256);
            w.nrm = place(axis, 0, 0, nm);
            w.last = (n_left == 0);
            if (w.last && $urandom_range(0, 7) == 0) w.nrm = rand_vec();
            push_vertex(w);
          end
        end
      end else if (kind < 8) begin
        n_pts = $urandom_range(1, 6);
        vary = ($urandom_range(0, 3) == 0);
        w.pt = rand_vec();
        w.nrm = rand_vec();
        for (int k = 0; k < n_pts; k++) begin
          if (vary) begin
            w.pt = rand_vec();
            w.nrm = rand_vec();
          end
          w.vert = rand_vec();
          w.last = (k == n_pts - 1);
          push_vertex(w);
        end
      end else begin
        repeat ($urandom_range(1, 8))
          push_vertex(mk_word(rand_vec(), rand_vec(), rand_vec(),
                              $urandom_range(0, 3) == 0));
      end
    end
    if (face_open) push_vertex(mk_word(rand_vec(), rand_vec(), rand_vec(), 1'b1));
  endtask

  initial begin
    rst = 1'b1;
    push = 1'b0;
    vert_x = '0;
    vert_y = '0;
    vert_z = '0;
    point_x = '0;
    point_y = '0;
    point_z = '0;
    normal_x = '0;
    normal_y = '0;
    normal_z = '0;
    last_vertex = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_single_vertex_faces();
    test_two_vertex_faces();
    drain_results();
    test_square_face();
    test_extreme_triangle();
    drain_results();
    test_output_backpressure();
    test_random_faces();
    drain_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
